// File: rtl/pis_pkg.sv
// shared types and constants for the pixel intensity stretch block
// no dependencies; imported by every module of the block except pis_table_ram
package pis_pkg;

  // field widths fixed by the item formats
  localparam int SAMPLE_W   = 32;
  localparam int INDEX_W    = 10;
  localparam int ENTRY_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int NUM_CHAN   = 3;

  // configuration port geometry: registers at 8-byte spacing
  localparam int PADDR_W    = 6;
  localparam int PDATA_W    = 64;
  localparam int REG_LSB    = 3;

  // fractional bits dropped at each step
  localparam int SCALE_FRAC = 16;
  localparam int PLAIN_SHIFT   = 28;
  localparam int STRETCH_SHIFT = 18;

  // scaled value and product widths
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int VAL_W      = PROD_W - SCALE_FRAC;
  localparam int VLOW_W     = PLAIN_SHIFT + CHAN_W;
  localparam int MUL_W      = VLOW_W + GAIN_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  // null handling modes
  localparam logic [1:0] NULL_MATCH = 2'd1;
  localparam logic [1:0] NULL_NAN   = 2'd2;

  // register map
  typedef enum logic [2:0] {
    REG_OFFSET     = 3'd0,
    REG_SCALE      = 3'd1,
    REG_NULL_VALUE = 3'd2,
    REG_NULL_MODE  = 3'd3,
    REG_WINDOW     = 3'd4,
    REG_GAINS      = 3'd5,
    REG_STRETCH    = 3'd6
  } reg_index_t;

  // reset values of the registers
  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [47:0] GAINS_RESET = 48'h1000_1000_1000;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] pixel_value;
    logic                       is_nan;
    logic [INDEX_W-1:0]         table_index;
    logic [ENTRY_W-1:0]         table_value;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic [COUNT_W-1:0] null_count;
    logic [COUNT_W-1:0] low_count;
    logic [COUNT_W-1:0] high_count;
  } result_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] offset;
    logic [SAMPLE_W-1:0]        scale;
    logic signed [SAMPLE_W-1:0] null_value;
    logic [1:0]                 null_mode;
    logic [2*SAMPLE_W-1:0]      valid_window;
    logic [NUM_CHAN*GAIN_W-1:0] channel_gains;
    logic                       stretch_enable;
  } cfg_t;

  // counter bump requests from the pipeline
  typedef struct packed {
    logic null_hit;
    logic below_hit;
    logic above_hit;
  } count_bump_t;

endpackage

// File: rtl/pixel_intensity_stretch.sv
// pixel intensity stretch: q16.16 sample to rgba8 with optional table stretch
// path: an accepted request passes stages a, b, c and d, then the result register
// throughput: one request per cycle while the result side takes results;
//   a stalled result holds the whole five-stage pipeline in place
// reset: counters cleared, registers to defaults; stretch table is not cleared
// depends on pis_pkg, pis_cfg, pis_counters, pis_table_ram
module pixel_intensity_stretch #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  pis_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output pis_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pis_pkg::PADDR_W-1:0] paddr,
  input  logic [pis_pkg::PDATA_W-1:0] pwdata,
  output logic [pis_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pis_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t        cfg;
  logic        adv;
  count_bump_t bump;
  logic [COUNT_BITS-1:0] null_cnt, below_cnt, above_cnt;

  // front classification
  logic signed [SAMPLE_W:0]   diff;
  logic signed [SAMPLE_W-1:0] vlo, vhi;
  logic is_null, below, above, invalid;

  // stage a
  logic                a_valid, a_kind, a_null, a_below, a_above, a_invalid, a_nan, a_pos;
  logic [INDEX_W-1:0]  a_index;
  logic [ENTRY_W-1:0]  a_tvalue;
  logic [SAMPLE_W-1:0] a_diff;

  // stage b
  logic               b_valid, b_kind, b_keep, b_show;
  logic [INDEX_W-1:0] b_index;
  logic [ENTRY_W-1:0] b_tvalue;
  logic [PROD_W-1:0]  b_prod;

  // stage c and table access
  logic                  c_valid, c_kind, c_keep, c_show, c_vsat;
  logic [VLOW_W-1:0]     c_vlow;
  logic [COUNT_BITS-1:0] c_null, c_below, c_above;
  logic [VAL_W-1:0]      vval;
  logic [SAMPLE_W-1:0]   ip;
  logic [AW+INDEX_W-1:0] index_ext;
  logic                  tbl_we, tbl_re;
  logic [AW-1:0]         tbl_waddr, tbl_raddr;
  logic [ENTRY_W-1:0]    tbl_rdata;

  // stage d
  logic                  d_valid, d_kind, d_keep, d_show;
  logic [COUNT_BITS-1:0] d_null, d_below, d_above;
  logic [MUL_W-1:0]      d_prod [NUM_CHAN];
  logic                  d_sat  [NUM_CHAN];
  logic [VLOW_W-1:0]     mul_op;
  logic [MUL_W-1:0]      mul    [NUM_CHAN];
  logic [GAIN_W-1:0]     gain   [NUM_CHAN];

  // output stage
  logic [CHAN_W-1:0]        chan [NUM_CHAN];
  logic [COUNT_BITS+31:0]   null_ext, below_ext, above_ext;

  pis_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the pipeline moves as one whenever the result register can take data
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // classify the incoming sample
  always_comb begin
    vlo     = signed'(cfg.valid_window[SAMPLE_W-1:0]);
    vhi     = signed'(cfg.valid_window[2*SAMPLE_W-1:SAMPLE_W]);
    diff    = {item.pixel_value[SAMPLE_W-1], item.pixel_value}
            - {cfg.offset[SAMPLE_W-1], cfg.offset};
    is_null = (cfg.null_mode == NULL_MATCH && !item.is_nan
               && item.pixel_value == cfg.null_value)
           || (cfg.null_mode == NULL_NAN && item.is_nan);
    below   = !item.is_nan && item.pixel_value < vlo;
    above   = !item.is_nan && item.pixel_value > vhi;
    invalid = is_null || (vlo != '0 && below) || (vhi != '0 && above);
  end

  // stage a registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind    <= item.kind;
      a_index   <= item.table_index;
      a_tvalue  <= item.table_value;
      a_null    <= is_null;
      a_below   <= below;
      a_above   <= above;
      a_invalid <= invalid;
      a_nan     <= item.is_nan;
      a_pos     <= !diff[SAMPLE_W] && diff != '0;
      a_diff    <= unsigned'(diff[SAMPLE_W-1:0]);
    end
  end

  // invalid pixels bump their counters as they leave stage a
  always_comb begin
    bump.null_hit  = adv && a_valid && a_kind == KIND_PIXEL && a_invalid && a_null;
    bump.below_hit = adv && a_valid && a_kind == KIND_PIXEL && a_invalid && a_below;
    bump.above_hit = adv && a_valid && a_kind == KIND_PIXEL && a_invalid && a_above;
  end

  pis_counters #(.COUNT_BITS(COUNT_BITS)) u_counters (
    .clk       (clk),
    .rst       (rst),
    .bump      (bump),
    .null_cnt  (null_cnt),
    .below_cnt (below_cnt),
    .above_cnt (above_cnt)
  );

  // stage b: offset sample times scale
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_kind   <= a_kind;
      b_index  <= a_index;
      b_tvalue <= a_tvalue;
      b_show   <= !a_invalid;
      b_keep   <= !a_invalid && !a_nan && a_pos;
      b_prod   <= PROD_W'(a_diff) * PROD_W'(cfg.scale);
    end
  end

  // table access: writes and lookups reach the table in request order
  always_comb begin
    vval      = b_prod[PROD_W-1:SCALE_FRAC];
    ip        = vval[VAL_W-1:VAL_W-SAMPLE_W];
    index_ext = {{AW{1'b0}}, b_index};
    tbl_waddr = index_ext[AW-1:0];
    tbl_we    = adv && b_valid && b_kind == KIND_TABLE
             && 32'(b_index) < TABLE_DEPTH;
    tbl_re    = adv && b_valid && b_kind == KIND_PIXEL;
    if (ip >= SAMPLE_W'(TABLE_DEPTH)) begin
      tbl_raddr = AW'(TABLE_DEPTH - 1);
    end else begin
      tbl_raddr = ip[AW-1:0];
    end
  end

  pis_table_ram #(.DEPTH(TABLE_DEPTH), .DATA_W(ENTRY_W)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (b_tvalue),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // stage c registers, counter snapshot after this pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_kind  <= b_kind;
      c_show  <= b_show;
      c_keep  <= b_keep;
      c_vsat  <= |vval[VAL_W-1:VLOW_W];
      c_vlow  <= vval[VLOW_W-1:0];
      c_null  <= null_cnt;
      c_below <= below_cnt;
      c_above <= above_cnt;
    end
  end

  // stage d: channel gains on the table entry or the scaled value
  always_comb begin
    if (cfg.stretch_enable) begin
      mul_op = VLOW_W'(tbl_rdata);
    end else begin
      mul_op = c_vlow;
    end
    for (int j = 0; j < NUM_CHAN; j++) begin
      gain[j] = cfg.channel_gains[GAIN_W*j +: GAIN_W];
      mul[j]  = MUL_W'(mul_op) * MUL_W'(gain[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_kind  <= c_kind;
      d_show  <= c_show;
      d_keep  <= c_keep;
      d_null  <= c_null;
      d_below <= c_below;
      d_above <= c_above;
      for (int j = 0; j < NUM_CHAN; j++) begin
        d_prod[j] <= mul[j];
        // a scaled value of 2^36 or more saturates any nonzero gain
        d_sat[j]  <= !cfg.stretch_enable && c_vsat && gain[j] != '0;
      end
    end
  end

  // final shift and clamp per channel; pixels not kept come out as zero
  always_comb begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      if (!d_keep) begin
        chan[j] = CHAN_ZERO;
      end else if (d_sat[j]) begin
        chan[j] = CHAN_MAX;
      end else if (cfg.stretch_enable) begin
        if (|d_prod[j][MUL_W-1:STRETCH_SHIFT+CHAN_W]) begin
          chan[j] = CHAN_MAX;
        end else begin
          chan[j] = d_prod[j][STRETCH_SHIFT +: CHAN_W];
        end
      end else begin
        if (|d_prod[j][MUL_W-1:PLAIN_SHIFT+CHAN_W]) begin
          chan[j] = CHAN_MAX;
        end else begin
          chan[j] = d_prod[j][PLAIN_SHIFT +: CHAN_W];
        end
      end
    end
    null_ext  = {32'd0, d_null};
    below_ext = {32'd0, d_below};
    above_ext = {32'd0, d_above};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= d_valid && d_kind == KIND_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.red        <= chan[0];
      result.green      <= chan[1];
      result.blue       <= chan[2];
      result.alpha      <= d_show ? CHAN_MAX : CHAN_ZERO;
      result.null_count <= null_ext[COUNT_W-1:0];
      result.low_count  <= below_ext[COUNT_W-1:0];
      result.high_count <= above_ext[COUNT_W-1:0];
    end
  end

endmodule

// File: rtl/pis_cfg.sv
// configuration register file behind the apb-style port
// depends on pis_pkg for the register map and cfg_t
module pis_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pis_pkg::PADDR_W-1:0] paddr,
  input  logic [pis_pkg::PDATA_W-1:0] pwdata,
  output logic [pis_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output pis_pkg::cfg_t               cfg
);
  import pis_pkg::*;

  reg_index_t sel;
  logic       wr;

  assign pready = 1'b1;
  assign sel    = reg_index_t'(paddr[PADDR_W-1:REG_LSB]);
  assign wr     = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset         <= '0;
      cfg.scale          <= SCALE_RESET;
      cfg.null_value     <= '0;
      cfg.null_mode      <= '0;
      cfg.valid_window   <= '0;
      cfg.channel_gains  <= GAINS_RESET;
      cfg.stretch_enable <= 1'b0;
    end else if (wr) begin
      case (sel)
        REG_OFFSET:     cfg.offset         <= signed'(pwdata[SAMPLE_W-1:0]);
        REG_SCALE:      cfg.scale          <= pwdata[SAMPLE_W-1:0];
        REG_NULL_VALUE: cfg.null_value     <= signed'(pwdata[SAMPLE_W-1:0]);
        REG_NULL_MODE:  cfg.null_mode      <= pwdata[1:0];
        REG_WINDOW:     cfg.valid_window   <= pwdata;
        REG_GAINS:      cfg.channel_gains  <= pwdata[NUM_CHAN*GAIN_W-1:0];
        REG_STRETCH:    cfg.stretch_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (sel)
      REG_OFFSET:     prdata = {32'd0, unsigned'(cfg.offset)};
      REG_SCALE:      prdata = {32'd0, cfg.scale};
      REG_NULL_VALUE: prdata = {32'd0, unsigned'(cfg.null_value)};
      REG_NULL_MODE:  prdata = {62'd0, cfg.null_mode};
      REG_WINDOW:     prdata = cfg.valid_window;
      REG_GAINS:      prdata = {16'd0, cfg.channel_gains};
      REG_STRETCH:    prdata = {63'd0, cfg.stretch_enable};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: rtl/pis_table_ram.sv
// stretch table storage: one synchronous write port and one read port, read data registered
// no package dependencies; depth set by the top level
module pis_table_ram #(
  parameter  int DEPTH = 1024,
  parameter  int DATA_W = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pis_counters.sv
// saturating null, below and above counters
// depends on pis_pkg for count_bump_t
module pis_counters #(
  parameter int COUNT_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pis_pkg::count_bump_t    bump,
  output logic [COUNT_BITS-1:0]   null_cnt,
  output logic [COUNT_BITS-1:0]   below_cnt,
  output logic [COUNT_BITS-1:0]   above_cnt
);
  import pis_pkg::*;

  // each counter stops at all ones
  always_ff @(posedge clk) begin
    if (rst) begin
      null_cnt  <= '0;
      below_cnt <= '0;
      above_cnt <= '0;
    end else begin
      if (bump.null_hit && null_cnt != '1) begin
        null_cnt <= null_cnt + 1'b1;
      end
      if (bump.below_hit && below_cnt != '1) begin
        below_cnt <= below_cnt + 1'b1;
      end
      if (bump.above_hit && above_cnt != '1) begin
        above_cnt <= above_cnt + 1'b1;
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for pixel_intensity_stretch: q16.16 samples to rgba8 pixels
// depends on pis_pkg and the block's rtl; holds its own pixel predictor and stimulus
module tb;
  import pis_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int COUNT_BITS  = 32;

  // null modes without a name in the package
  localparam logic [1:0] NULL_OFF   = 2'd0;
  localparam logic [1:0] NULL_SPARE = 2'd3;

  // how a pixel falls out against the current settings
  typedef struct packed {
    logic        null_hit;
    logic        below_hit;
    logic        above_hit;
    logic        invalid;
    logic        lit;
    logic [63:0] level;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  item_t               item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // predictor state
  cfg_t                cfg_now;
  logic [ENTRY_W-1:0]  asinh_lut [TABLE_DEPTH];
  logic [COUNT_W-1:0]  null_tally = '0;
  logic [COUNT_W-1:0]  low_tally = '0;
  logic [COUNT_W-1:0]  high_tally = '0;

  // stimulus side bookkeeping
  item_t               stream_requests [$];
  result_t             expected_rgba [$];
  bit                  lut_loaded [TABLE_DEPTH];
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  fault_count = 0;
  logic                stall_arm = 1'b0;
  bit                  stall_done = 1'b0;
  int                  stall_left = 0;

  pixel_intensity_stretch #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic cfg_t make_cfg(logic [31:0] off, logic [31:0] scl, logic [31:0] nv,
                                    logic [1:0] mode, logic [63:0] win, logic [47:0] gains,
                                    logic stretch);
    cfg_t c;
    c.offset         = off;
    c.scale          = scl;
    c.null_value     = nv;
    c.null_mode      = mode;
    c.valid_window   = win;
    c.channel_gains  = gains;
    c.stretch_enable = stretch;
    return c;
  endfunction

  // null and window checks, then the scaled level of a lit pixel
  function automatic verdict_t judge_pixel(item_t it);
    verdict_t d;
    logic signed [31:0] pv;
    logic signed [31:0] vlo;
    logic signed [31:0] vhi;
    longint diff;
    pv  = it.pixel_value;
    vlo = cfg_now.valid_window[31:0];
    vhi = cfg_now.valid_window[63:32];
    d.null_hit = (cfg_now.null_mode == NULL_MATCH && !it.is_nan && pv == cfg_now.null_value) ||
                 (cfg_now.null_mode == NULL_NAN && it.is_nan);
    // raw compares, even against a disabled bound
    d.below_hit = !it.is_nan && (pv < vlo);
    d.above_hit = !it.is_nan && (pv > vhi);
    d.invalid = d.null_hit || (vlo != 0 && d.below_hit) || (vhi != 0 && d.above_hit);
    diff = longint'(pv) - longint'(cfg_now.offset);
    d.lit = !d.invalid && !it.is_nan && diff > 0;
    d.level = d.lit ? (64'(diff) * 64'(cfg_now.scale)) >> SCALE_FRAC : 64'd0;
    return d;
  endfunction

  // table slot from the integer part, pinned to the last entry
  function automatic int lookup_slot(logic [63:0] level);
    logic [63:0] ip;
    ip = level >> SCALE_FRAC;
    return (ip > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : int'(ip);
  endfunction

  // expected rgba and counters for one accepted pixel
  function automatic result_t shade_pixel(item_t it);
    verdict_t d;
    result_t r;
    logic [CHAN_W-1:0] chan [NUM_CHAN];
    logic [GAIN_W-1:0] g;
    logic [79:0] prod;
    int slot;
    d = judge_pixel(it);
    for (int j = 0; j < NUM_CHAN; j++) chan[j] = CHAN_ZERO;
    if (d.invalid) begin
      if (d.null_hit && null_tally != '1) null_tally++;
      if (d.below_hit && low_tally != '1) low_tally++;
      if (d.above_hit && high_tally != '1) high_tally++;
      r.alpha = CHAN_ZERO;
    end else begin
      r.alpha = CHAN_MAX;
      if (d.lit) begin
        slot = lookup_slot(d.level);
        for (int j = 0; j < NUM_CHAN; j++) begin
          g = cfg_now.channel_gains[GAIN_W*j +: GAIN_W];
          if (cfg_now.stretch_enable) begin
            prod = (80'(asinh_lut[slot]) * 80'(g)) >> STRETCH_SHIFT;
          end else begin
            prod = (80'(d.level) * 80'(g)) >> PLAIN_SHIFT;
          end
          chan[j] = (prod > 80'd255) ? CHAN_MAX : prod[CHAN_W-1:0];
        end
      end
    end
    r.red        = chan[0];
    r.green      = chan[1];
    r.blue       = chan[2];
    r.null_count = null_tally;
    r.low_count  = low_tally;
    r.high_count = high_tally;
    return r;
  endfunction

  function automatic void queue_table(int idx, logic [ENTRY_W-1:0] val);
    item_t t;
    t.kind        = KIND_TABLE;
    t.pixel_value = $urandom;
    t.is_nan      = 1'($urandom_range(1));
    t.table_index = INDEX_W'(idx);
    t.table_value = val;
    lut_loaded[idx] = 1'b1;
    stream_requests.push_back(t);
  endfunction

  // a stretched pixel never reads an entry that was never loaded
  function automatic void queue_pixel(logic [31:0] sample, logic nan);
    item_t p;
    verdict_t d;
    int slot;
    p.kind        = KIND_PIXEL;
    p.pixel_value = sample;
    p.is_nan      = nan;
    p.table_index = INDEX_W'($urandom);
    p.table_value = ENTRY_W'($urandom);
    d = judge_pixel(p);
    if (cfg_now.stretch_enable && d.lit) begin
      slot = lookup_slot(d.level);
      if (!lut_loaded[slot]) queue_table(slot, ENTRY_W'($urandom));
    end
    stream_requests.push_back(p);
  endfunction

  // samples biased toward null value, window edges and the useful range
  function automatic logic [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return cfg_now.null_value;
    if (r < 18) begin
      case ($urandom_range(4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (r < 30) return cfg_now.valid_window[31:0] + $urandom_range(4) - 2;
    if (r < 40) return cfg_now.valid_window[63:32] + $urandom_range(4) - 2;
    if (r < 60) return $urandom;
    return cfg_now.offset + $urandom_range(0, 32'h0200_0000);
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    logic [31:0] lo;
    logic [31:0] hi;
    c.offset = ($urandom_range(3) == 0) ? $urandom
             : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    c.scale = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h4000, 32'h0004_0000);
    c.null_value = $urandom_range(1) ? $urandom
                 : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    c.null_mode = 2'($urandom_range(3));
    lo = ($urandom_range(3) == 0) ? 32'h0 : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    hi = ($urandom_range(3) == 0) ? 32'h0 : lo + $urandom_range(32'h0010_0000, 32'h0400_0000);
    c.valid_window = ($urandom_range(4) == 0) ? {$urandom, $urandom} : {hi, lo};
    for (int j = 0; j < NUM_CHAN; j++) begin
      c.channel_gains[GAIN_W*j +: GAIN_W] = GAIN_W'(($urandom_range(4) == 0) ? $urandom
                                                    : $urandom_range(0, 16'h2000));
    end
    c.stretch_enable = 1'($urandom_range(1));
    return c;
  endfunction

  function automatic void random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        queue_table($urandom_range(1) ? $urandom_range(0, 63) : $urandom_range(0, TABLE_DEPTH - 1),
                    ENTRY_W'($urandom));
      end else begin
        queue_pixel(pick_sample(), $urandom_range(99) < 10);
      end
    end
  endfunction

  // one apb transfer: setup, then access, then back to idle
  task automatic reg_access(logic wr, reg_index_t r, logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({r, {REG_LSB{1'b0}}});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write every register, read each back, then switch the predictor over
  task automatic apply_cfg(cfg_t c);
    logic [PDATA_W-1:0] vals [7];
    logic [PDATA_W-1:0] masks [7];
    logic [PDATA_W-1:0] got;
    vals[REG_OFFSET]      = {32'h0, c.offset};
    vals[REG_SCALE]       = {32'h0, c.scale};
    vals[REG_NULL_VALUE]  = {32'h0, c.null_value};
    vals[REG_NULL_MODE]   = {62'h0, c.null_mode};
    vals[REG_WINDOW]      = c.valid_window;
    vals[REG_GAINS]       = {16'h0, c.channel_gains};
    vals[REG_STRETCH]     = {63'h0, c.stretch_enable};
    masks[REG_OFFSET]     = 64'hFFFF_FFFF;
    masks[REG_SCALE]      = 64'hFFFF_FFFF;
    masks[REG_NULL_VALUE] = 64'hFFFF_FFFF;
    masks[REG_NULL_MODE]  = 64'h3;
    masks[REG_WINDOW]     = '1;
    masks[REG_GAINS]      = 64'hFFFF_FFFF_FFFF;
    masks[REG_STRETCH]    = 64'h1;
    for (int i = 0; i < 7; i++) begin
      reg_access(1'b1, reg_index_t'(i), vals[i], got);
      reg_access(1'b0, reg_index_t'(i), '0, got);
      if ((got & masks[i]) !== (vals[i] & masks[i])) begin
        fault_count++;
        $display("%0t register %0d readback expected %h got %h", $time, i,
                 vals[i] & masks[i], got & masks[i]);
      end
    end
    cfg_now = c;
  endtask

  // all requests taken and all pixels back, then room for a trailing table write
  // sampled at the falling edge so the driver and monitor have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (stream_requests.size() != 0 || item_valid || expected_rgba.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // request driver: predict on accept, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) begin
        if (item.kind == KIND_PIXEL) begin
          expected_rgba.push_back(shade_pixel(item));
        end else begin
          asinh_lut[item.table_index] = item.table_value;
        end
      end
      if (stream_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item_valid <= 1'b1;
        item       <= stream_requests.pop_front();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result side backpressure, with one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_left   <= 400;
      stall_done   <= 1'b1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      $display("%0t %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // result monitor
  always @(posedge clk) begin : result_mon
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_rgba.size() == 0) begin
        fault_count++;
        $display("%0t unexpected result expected none got %h", $time, result);
      end else begin
        want = expected_rgba.pop_front();
        check_field("red", 32'(want.red), 32'(result.red));
        check_field("green", 32'(want.green), 32'(result.green));
        check_field("blue", 32'(want.blue), 32'(result.blue));
        check_field("alpha", 32'(want.alpha), 32'(result.alpha));
        check_field("null_count", want.null_count, result.null_count);
        check_field("low_count", want.low_count, result.low_count);
        check_field("high_count", want.high_count, result.high_count);
      end
    end
  end

  // stimulus sequence
  initial begin
    cfg_t c;
    cfg_now = make_cfg(32'h0, SCALE_RESET, 32'h0, NULL_OFF, 64'h0, GAINS_RESET, 1'b0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 86;

    // reset settings: 2.5 at unity gain
    queue_pixel(32'h0002_8000, 1'b0);
    wait_drained();

    // null match, low bound disabled, high bound 100.0, uneven gains
    apply_cfg(make_cfg(32'h0, 32'h0001_0000, 32'hFFFB_0000, NULL_MATCH,
                       {32'h0064_0000, 32'h0}, 48'h2000_0800_1000, 1'b0));
    queue_pixel(32'hFFFB_0000, 1'b0);  // null, also counted low against the disabled bound
    queue_pixel(32'h7FFF_FFFF, 1'b0);  // above the high bound
    queue_pixel(32'h8000_0000, 1'b0);  // valid, below the black level
    queue_pixel(32'h0001_8000, 1'b0);
    queue_pixel(32'h0064_0000, 1'b0);
    queue_pixel(32'h0063_FFFF, 1'b0);
    queue_pixel(32'h0, 1'b1);          // nan that is not null
    queue_pixel(32'h0, 1'b0);
    queue_table($urandom_range(0, TABLE_DEPTH - 1), ENTRY_W'($urandom));
    wait_drained();

    // nan is null, widest scale and gains, stretch on
    apply_cfg(make_cfg(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, NULL_NAN,
                       64'h0, 48'hFFFF_FFFF_FFFF, 1'b1));
    queue_table(TABLE_DEPTH - 1, 16'hFFFF);
    queue_table(0, 16'h0040);
    queue_pixel(32'h0, 1'b1);          // null nan
    queue_pixel(32'h7FFF_FFFF, 1'b0);  // index pinned to the last entry
    queue_pixel(32'h8000_0000, 1'b0);  // zero difference
    queue_pixel(32'h8000_0001, 1'b0);  // first entry
    wait_drained();

    // spare null mode, both bounds all ones, zero scale and gains
    apply_cfg(make_cfg(32'h7FFF_FFFF, 32'h0, 32'h0, NULL_SPARE,
                       64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b0));
    queue_pixel(32'h0, 1'b1);
    queue_pixel(32'h0, 1'b0);
    queue_pixel(32'h8000_0000, 1'b0);
    queue_pixel(32'hFFFF_FFFF, 1'b0);
    wait_drained();

    // random phases, idling pattern changes every three
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 86;
      end else if (ph < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        2: c = make_cfg(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, NULL_MATCH,
                        {32'h7FFF_FFFF, 32'h8000_0000}, 48'hFFFF_FFFF_FFFF, 1'b0);
        5: c = make_cfg(32'h0, 32'h0, 32'h0, NULL_OFF, 64'h0, 48'h0, 1'b1);
        default: c = random_cfg();
      endcase
      apply_cfg(c);
      random_phase(145);
      // receiver holds off while the sender keeps pushing
      if (ph == 6) stall_arm <= 1'b1;
      wait_drained();
    end

    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
